/* sv/uv_sphere_tile_generator_macros.svh */
// Assertion helpers for the tile generator RTL.
`ifndef UV_SPHERE_TILE_GENERATOR_MACROS_SVH
`define UV_SPHERE_TILE_GENERATOR_MACROS_SVH

// Same-cycle implication, masked during reset.
`define UVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile generator check failed");

// Next-cycle implication, masked during reset.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile generator check failed");

`endif

/* sv/uvs_pkg.sv */
`default_nettype none
package uvs_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_SEGMENTS = 256;

    localparam int IDX_W  = 8;
    localparam int CFG_W  = 9;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DIV_W  = CNT_W + 1;
    localparam int NUM_W  = 17 + CNT_W;
    localparam int PH_W   = 16;
    localparam int NLANE  = 4;
    localparam int NSIN   = 2 * NLANE;

    localparam logic [IDX_W-1:0] REG_LAT = 8'd0;
    localparam logic [IDX_W-1:0] REG_LON = 8'd1;

    localparam logic [CNT_W-1:0] LAT_MIN = CNT_W'(2);
    localparam logic [CNT_W-1:0] LON_MIN = CNT_W'(3);
    localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);

    // lanes: left/right longitude phase, top/bottom latitude phase
    localparam int LANE_TH0 = 0;
    localparam int LANE_TH1 = 1;
    localparam int LANE_PH0 = 2;
    localparam int LANE_PH1 = 3;

    localparam logic [PH_W-1:0] PH_QUARTER = 16'h4000;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DIV_W-1:0] rem;
        logic [PH_W-1:0]  quo;
    } t_div_lane;

    typedef struct packed {
        logic                        vld;
        t_div_lane [NLANE-1:0]       lane;
    } t_div_stage;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int SIN_STAGES = 15;
    localparam int SIN_STEPS  = 4;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } t_sval;

    // reciprocals for the Horner divisions, floor(2^RCP_SH / c)
    localparam int RCP_SH = 38;
    localparam int RCP_W  = 38;
    localparam int MUL_W  = RCP_W + 32;
    localparam logic [RCP_W-1:0] RCP_72 = RCP_W'((64'd1 << RCP_SH) / 64'd72);
    localparam logic [RCP_W-1:0] RCP_42 = RCP_W'((64'd1 << RCP_SH) / 64'd42);
    localparam logic [RCP_W-1:0] RCP_20 = RCP_W'((64'd1 << RCP_SH) / 64'd20);
    localparam logic [RCP_W-1:0] RCP_6  = RCP_W'((64'd1 << RCP_SH) / 64'd6);

    function automatic logic [31:0] step_div(input int s);
        case (s)
            0:       step_div = 32'd72;
            1:       step_div = 32'd42;
            2:       step_div = 32'd20;
            default: step_div = 32'd6;
        endcase
    endfunction

    function automatic logic [RCP_W-1:0] step_rcp(input int s);
        case (s)
            0:       step_rcp = RCP_72;
            1:       step_rcp = RCP_42;
            2:       step_rcp = RCP_20;
            default: step_rcp = RCP_6;
        endcase
    endfunction

    localparam int OUT_SHIFT = 62 - COORD_BITS;
    localparam int PROD_W    = 62;
    localparam int CORNER_W  = 3;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

    // corner order TL, BL, BR, TL, BR, TR
    function automatic logic corner_right(input logic [CORNER_W-1:0] k);
        case (k)
            3'd2, 3'd4, 3'd5: corner_right = 1'b1;
            default:          corner_right = 1'b0;
        endcase
    endfunction

    function automatic logic corner_bottom(input logic [CORNER_W-1:0] k);
        case (k)
            3'd1, 3'd2, 3'd4: corner_bottom = 1'b1;
            default:          corner_bottom = 1'b0;
        endcase
    endfunction

endpackage
`default_nettype wire

/* sv/uvs_div_cell.sv */
`default_nettype none
module uvs_div_cell
    import uvs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_div_stage       i_stage,
    input  wire logic [DIV_W-1:0] i_dlon,
    input  wire logic [DIV_W-1:0] i_dlat,
    output t_div_stage            o_stage
);

    logic                  r_vld;
    t_div_lane [NLANE-1:0] r_lane;
    t_div_lane [NLANE-1:0] n_lane;

    // one restoring step per lane: shift in a numerator bit, subtract if it fits
    always_comb begin
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] d;
        logic             ge;
        for (int l = 0; l < NLANE; l++) begin
            d  = (l < LANE_PH0) ? i_dlon : i_dlat;
            t  = {i_stage.lane[l].rem, i_stage.lane[l].num[NUM_W-1]};
            ge = (t >= {1'b0, d});
            n_lane[l].rem = ge ? DIV_W'(t - {1'b0, d}) : DIV_W'(t);
            n_lane[l].num = {i_stage.lane[l].num[NUM_W-2:0], 1'b0};
            n_lane[l].quo = {i_stage.lane[l].quo[PH_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_stage.vld  = r_vld;
    assign o_stage.lane = r_lane;

endmodule
`default_nettype wire

/* sv/uvs_sin_pipe.sv */
`default_nettype none
module uvs_sin_pipe
    import uvs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [PH_W-1:0] i_phase,
    output t_sval                o_val
);

    logic [14:0] r_rr;
    logic        r_ng1;
    logic [30:0] r_x2;
    logic        r_ng2;
    logic [30:0] r_x3;
    logic [31:0] r_sq3;
    logic        r_ng3;

    logic [31:0] w_u  [0:SIN_STEPS];
    logic        w_ng [0:SIN_STEPS];
    logic [31:0] w_sq [0:SIN_STEPS-1];
    logic [30:0] w_x  [0:SIN_STEPS-1];

    // fold onto the first quarter wave, keep the half-wave sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr  <= i_phase[14] ? 15'(15'd16384 - {1'b0, i_phase[13:0]})
                                 : {1'b0, i_phase[13:0]};
            r_ng1 <= i_phase[15];
            r_x2  <= 31'((47'(r_rr) * 47'(PI_Q30)) >> 15);
            r_ng2 <= r_ng1;
            r_x3  <= r_x2;
            r_sq3 <= 32'((62'(r_x2) * 62'(r_x2)) >> 30);
            r_ng3 <= r_ng2;
        end
    end

    assign w_u[0]  = r_sq3;
    assign w_sq[0] = r_sq3;
    assign w_x[0]  = r_x3;
    assign w_ng[0] = r_ng3;

    for (genvar s = 0; s < SIN_STEPS; s++) begin : g_step
        logic [31:0] r_aq, r_au, r_asq;
        logic [30:0] r_ax, r_bx, r_bt;
        logic [31:0] r_bsq, r_cu;
        logic        r_ang, r_bng, r_cng;
        logic [31:0] n_rem;
        logic [31:0] n_fac;

        assign n_rem = r_au - 32'(r_aq * step_div(s));
        assign n_fac = (s == SIN_STEPS - 1) ? {1'b0, r_bx} : r_bsq;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // estimate the quotient, then correct by one
                r_aq  <= 32'((MUL_W'(w_u[s]) * MUL_W'(step_rcp(s))) >> RCP_SH);
                r_au  <= w_u[s];
                r_asq <= w_sq[s];
                r_ax  <= w_x[s];
                r_ang <= w_ng[s];
                r_bt  <= ONE_Q30 - 31'(r_aq + 32'(n_rem >= step_div(s)));
                r_bsq <= r_asq;
                r_bx  <= r_ax;
                r_bng <= r_ang;
                r_cu  <= 32'((63'(n_fac) * 63'(r_bt)) >> 30);
                r_cng <= r_bng;
            end
        end

        assign w_u[s+1]  = r_cu;
        assign w_ng[s+1] = r_cng;

        if (s < SIN_STEPS - 1) begin : g_fwd
            logic [31:0] r_csq;
            logic [30:0] r_cx;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_csq <= r_bsq;
                    r_cx  <= r_bx;
                end
            end
            assign w_sq[s+1] = r_csq;
            assign w_x[s+1]  = r_cx;
        end
    end

    assign o_val.neg = w_ng[SIN_STEPS];
    assign o_val.mag = (w_u[SIN_STEPS] > {1'b0, ONE_Q30}) ? ONE_Q30 : 31'(w_u[SIN_STEPS]);

endmodule
`default_nettype wire

/* sv/uvs_vtx_out.sv */
`default_nettype none
module uvs_vtx_out
    import uvs_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    input  wire t_sval [NSIN-1:0]           i_vals,
    output logic                            o_adv,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [COORD_BITS-1:0]    o_pos_x,
    output logic signed [COORD_BITS-1:0]    o_pos_y,
    output logic signed [COORD_BITS-1:0]    o_pos_z,
    output logic signed [COORD_BITS-1:0]    o_norm_x,
    output logic signed [COORD_BITS-1:0]    o_norm_y,
    output logic signed [COORD_BITS-1:0]    o_norm_z,
    output logic [CORNER_W-1:0]             o_corner,
    output logic                            o_last
);

    logic                r_hv;
    logic [CORNER_W-1:0] r_hk;
    t_sval [NSIN-1:0]    r_vals;

    logic                r_mv;
    logic [PROD_W-1:0]   r_mx, r_my, r_mz;
    logic                r_nx, r_ny, r_nz;
    logic [CORNER_W-1:0] r_mk;

    logic                r_ov;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz, r_qx, r_qy, r_qz;
    logic [CORNER_W-1:0] r_ok;

    logic  w_move, w_emit;
    t_sval w_sp, w_cp, w_st, w_ct;

    function automatic logic signed [COORD_BITS-1:0] round_pos(
        input logic [PROD_W-1:0] m, input logic neg);
        logic [PROD_W-1:0]     r;
        logic [COORD_BITS-1:0] v;
        r = (m + (PROD_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        v = COORD_BITS'(r);
        round_pos = neg ? -v : v;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] twice_sat(
        input logic signed [COORD_BITS-1:0] p);
        logic signed [COORD_BITS:0] n;
        n = {p, 1'b0};
        if (n > (COORD_BITS + 1)'((1 << (COORD_BITS - 1)) - 1)) begin
            twice_sat = {1'b0, {(COORD_BITS - 1){1'b1}}};
        end else begin
            twice_sat = COORD_BITS'(n);
        end
    endfunction

    assign w_move = !r_ov || i_ready;
    assign w_emit = r_hv && (!r_mv || w_move);
    assign o_adv  = !r_hv || (w_emit && (r_hk == LAST_CORNER));

    always_comb begin
        w_st = corner_right(r_hk)  ? r_vals[2*LANE_TH1]     : r_vals[2*LANE_TH0];
        w_ct = corner_right(r_hk)  ? r_vals[2*LANE_TH1 + 1] : r_vals[2*LANE_TH0 + 1];
        w_sp = corner_bottom(r_hk) ? r_vals[2*LANE_PH1]     : r_vals[2*LANE_PH0];
        w_cp = corner_bottom(r_hk) ? r_vals[2*LANE_PH1 + 1] : r_vals[2*LANE_PH0 + 1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_hk <= '0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_adv) begin
                r_hv <= i_vld;
                r_hk <= '0;
            end else if (w_emit) begin
                r_hk <= r_hk + CORNER_W'(1);
            end
            if (!r_mv || w_move) begin
                r_mv <= w_emit;
            end
            if (w_move) begin
                r_ov <= r_mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_vld) begin
            r_vals <= i_vals;
        end
        if (!r_mv || w_move) begin
            r_mx <= PROD_W'(w_sp.mag) * PROD_W'(w_st.mag);
            r_nx <= w_sp.neg ^ w_st.neg;
            r_mz <= PROD_W'(w_sp.mag) * PROD_W'(w_ct.mag);
            r_nz <= w_sp.neg ^ w_ct.neg;
            r_my <= {w_cp.mag, 31'd0} >> 1;
            r_ny <= w_cp.neg;
            r_mk <= r_hk;
        end
        if (w_move) begin
            r_px <= round_pos(r_mx, r_nx);
            r_py <= round_pos(r_my, r_ny);
            r_pz <= round_pos(r_mz, r_nz);
            r_qx <= twice_sat(round_pos(r_mx, r_nx));
            r_qy <= twice_sat(round_pos(r_my, r_ny));
            r_qz <= twice_sat(round_pos(r_mz, r_nz));
            r_ok <= r_mk;
        end
    end

    assign o_valid  = r_ov;
    assign o_pos_x  = r_px;
    assign o_pos_y  = r_py;
    assign o_pos_z  = r_pz;
    assign o_norm_x = r_qx;
    assign o_norm_y = r_qy;
    assign o_norm_z = r_qz;
    assign o_corner = r_ok;
    assign o_last   = (r_ok == LAST_CORNER);

endmodule
`default_nettype wire

/* sv/uv_sphere_tile_generator.sv */
// Channel   Direction  Handshake          Payload
// tile in   input      i_valid / o_ready  i_lon_index, i_lat_index
// vertex    output     o_valid / i_ready  o_pos_*, o_norm_*, o_corner, o_last
// config    input      i_cfg_we           i_cfg_idx, i_cfg_data (no wait)
//
// A tile leaves the vertex output register one vertex per cycle while i_ready
// is high; the six-vertex serializer sets that rate. From the accepting edge
// to the first vertex the path runs through 26 divider cells, 15 sine stages
// and 3 output stages.
// Synchronous active-low reset clears valids and loads lat 2, lon 3.
// A stall on the vertex side holds the whole pipeline in place.
`default_nettype none
module uv_sphere_tile_generator
    import uvs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [IDX_W-1:0]        i_lon_index,
    input  wire logic [IDX_W-1:0]        i_lat_index,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [COORD_BITS-1:0] o_pos_x,
    output logic signed [COORD_BITS-1:0] o_pos_y,
    output logic signed [COORD_BITS-1:0] o_pos_z,
    output logic signed [COORD_BITS-1:0] o_norm_x,
    output logic signed [COORD_BITS-1:0] o_norm_y,
    output logic signed [COORD_BITS-1:0] o_norm_z,
    output logic [CORNER_W-1:0]          o_corner,
    output logic                         o_last,
    input  wire logic                    i_cfg_we,
    input  wire logic [IDX_W-1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    `include "uv_sphere_tile_generator_macros.svh"

    logic [CFG_W-1:0] r_lat, r_lon;
    logic [CNT_W-1:0] w_clat, w_clon;
    logic [DIV_W-1:0] w_dlat, w_dlon;
    logic             w_en;

    t_div_stage       w_stage [0:NUM_W];
    t_sval [NSIN-1:0] w_sin;
    logic [SIN_STAGES-1:0] r_sv;

    function automatic logic [CNT_W-1:0] clamp_count(
        input logic [CFG_W-1:0] v, input logic [CNT_W-1:0] lo);
        if (CNT_W'(v) < lo && v < CFG_W'(lo)) begin
            clamp_count = lo;
        end else if (v > CFG_W'(SEG_MAX)) begin
            clamp_count = SEG_MAX;
        end else begin
            clamp_count = CNT_W'(v);
        end
    endfunction

    // register writes; other indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= CFG_W'(LAT_MIN);
            r_lon <= CFG_W'(LON_MIN);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_LAT) begin
                r_lat <= i_cfg_data;
            end else if (i_cfg_idx == REG_LON) begin
                r_lon <= i_cfg_data;
            end
        end
    end

    assign w_clat = clamp_count(r_lat, LAT_MIN);
    assign w_clon = clamp_count(r_lon, LON_MIN);
    // rounded phase = (2 k span + n) / 2n, so divide by twice the count
    assign w_dlat = {w_clat, 1'b0};
    assign w_dlon = {w_clon, 1'b0};

    assign o_ready = w_en;

    // head of the divider chain: numerators for left/right and top/bottom edges
    always_comb begin
        w_stage[0].vld = i_valid;
        w_stage[0].lane[LANE_TH0].num = (NUM_W'(i_lon_index) << 17) + NUM_W'(w_clon);
        w_stage[0].lane[LANE_TH1].num =
            (NUM_W'({1'b0, i_lon_index} + 9'd1) << 17) + NUM_W'(w_clon);
        w_stage[0].lane[LANE_PH0].num = (NUM_W'(i_lat_index) << 16) + NUM_W'(w_clat);
        w_stage[0].lane[LANE_PH1].num =
            (NUM_W'({1'b0, i_lat_index} + 9'd1) << 16) + NUM_W'(w_clat);
        for (int l = 0; l < NLANE; l++) begin
            w_stage[0].lane[l].rem = '0;
            w_stage[0].lane[l].quo = '0;
        end
    end

    // one quotient bit per cell, low 16 bits give the phase modulo a turn
    for (genvar c = 0; c < NUM_W; c++) begin : g_div
        uvs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[c]),
            .i_dlon  (w_dlon),
            .i_dlat  (w_dlat),
            .o_stage (w_stage[c+1])
        );
    end

    // sine and cosine of each of the four phases
    for (genvar s = 0; s < NSIN; s++) begin : g_sin
        uvs_sin_pipe u_sin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_stage[NUM_W].lane[s/2].quo + ((s % 2 == 1) ? PH_QUARTER : '0)),
            .o_val   (w_sin[s])
        );
    end

    // valid tracking alongside the sine stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (w_en) begin
            r_sv <= {r_sv[SIN_STAGES-2:0], w_stage[NUM_W].vld};
        end
    end

    uvs_vtx_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_sv[SIN_STAGES-1]),
        .i_vals   (w_sin),
        .o_adv    (w_en),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_pos_x  (o_pos_x),
        .o_pos_y  (o_pos_y),
        .o_pos_z  (o_pos_z),
        .o_norm_x (o_norm_x),
        .o_norm_y (o_norm_y),
        .o_norm_z (o_norm_z),
        .o_corner (o_corner),
        .o_last   (o_last)
    );

    // a taken item enters the first divider cell
    `UVS_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, w_stage[1].vld)
    // vertices of one tile leave without bubbles
    `UVS_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_valid && i_ready && !o_last, o_valid)
    // last marks exactly the final corner
    `UVS_ASSERT_NOW(a_last, i_clk, i_rst_n, o_valid && o_last, o_corner == LAST_CORNER)

endmodule
`default_nettype wire
